### rtl/ustl_pkg.sv
package ustl_pkg;

  // Field widths
  localparam int CoordBits = 16;
  localparam int DistBits  = 16;
  localparam int RawBits   = 8;
  localparam int HeadBits  = 16;
  localparam int OutBits   = 18;

  // Internal widths, all derived from the field widths
  localparam int DeltaW = CoordBits + 1;
  localparam int SumW   = DistBits + 1;
  localparam int Sum2W  = 2 * SumW;
  localparam int Dif2W  = 2 * DistBits;
  localparam int B2W    = 2 * DeltaW;
  localparam int F1W    = Sum2W;
  localparam int QW     = F1W + B2W;
  localparam int RootW  = (QW + 1) / 2;
  localparam int KW     = ((B2W > Dif2W) ? B2W : Dif2W) + 2;
  localparam int KLoW   = KW / 2;
  localparam int KHiW   = KW - KLoW;
  localparam int F1LoW  = F1W / 2;
  localparam int F1HiW  = F1W - F1LoW;
  localparam int F2LoW  = B2W / 2;
  localparam int F2HiW  = B2W - F2LoW;
  localparam int SLoW   = RootW / 2;
  localparam int SHiW   = RootW - SLoW;
  localparam int NKW    = DeltaW + KW;
  localparam int NSW    = DeltaW + RootW + 1;
  localparam int NW     = ((NKW > NSW) ? NKW : NSW) + 1;
  localparam int MagW   = NW + 1;
  localparam int DivW   = B2W + 1;
  localparam int QuoW   = DistBits + 2;
  localparam int DrW    = (MagW > DivW + QuoW) ? MagW : DivW + QuoW;
  localparam int PosW   = ((CoordBits > QuoW + 1) ? CoordBits : QuoW + 1) + 1;

  // Raw echo status codes
  localparam logic [RawBits-1:0] RawOk    = RawBits'(0);
  localparam logic [RawBits-1:0] RawNoise = RawBits'(2);
  localparam logic [RawBits-1:0] RawBlind = RawBits'(16);

  localparam logic signed [PosW-1:0] SatHi = PosW'((1 << (OutBits - 1)) - 1);
  localparam logic signed [PosW-1:0] SatLo = -SatHi - PosW'(1);

  typedef enum logic [2:0] {
    StNormal  = 3'd0,
    StOver    = 3'd1,
    StBlind   = 3'd2,
    StNoise   = 3'd3,
    StInvalid = 3'd4
  } obst_status_e;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t                ax;
    coord_t                ay;
    logic [HeadBits-1:0]   heading;
    coord_t                bx;
    coord_t                by;
    logic [DistBits-1:0]   l;
    logic [RawBits-1:0]    ls;
    logic [DistBits-1:0]   r;
    logic [RawBits-1:0]    rs;
  } item_t;

  typedef struct packed {
    coord_t                   ax;
    coord_t                   ay;
    logic                     neg;
    obst_status_e             st;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic signed [KW-1:0]     k;
    logic [B2W-1:0]           b2;
  } geom_t;

  typedef struct packed {
    coord_t       ax;
    coord_t       ay;
    obst_status_e st;
    logic         neg_x;
    logic         neg_y;
  } div_tag_t;

  function automatic logic signed [OutBits-1:0] sat_out(input logic signed [PosW-1:0] v);
    logic signed [PosW-1:0] c;
    c = v;
    if (v > SatHi) c = SatHi;
    if (v < SatLo) c = SatLo;
    return OutBits'(c);
  endfunction

endpackage

### rtl/ustl_in_if.sv
interface ustl_in_if;
  import ustl_pkg::*;
  logic                valid;
  logic                ready;
  coord_t              sensor_a_x;
  coord_t              sensor_a_y;
  logic [HeadBits-1:0] sensor_a_heading;
  coord_t              sensor_b_x;
  coord_t              sensor_b_y;
  logic [DistBits-1:0] left_distance;
  logic [RawBits-1:0]  left_status;
  logic [DistBits-1:0] right_distance;
  logic [RawBits-1:0]  right_status;

  modport source (
    output valid, sensor_a_x, sensor_a_y, sensor_a_heading, sensor_b_x, sensor_b_y,
    output left_distance, left_status, right_distance, right_status,
    input  ready
  );
  modport sink (
    input  valid, sensor_a_x, sensor_a_y, sensor_a_heading, sensor_b_x, sensor_b_y,
    input  left_distance, left_status, right_distance, right_status,
    output ready
  );
endinterface

### rtl/ustl_out_if.sv
interface ustl_out_if;
  import ustl_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [OutBits-1:0] obstacle_x;
  logic signed [OutBits-1:0] obstacle_y;
  obst_status_e              obstacle_status;

  modport source (output valid, obstacle_x, obstacle_y, obstacle_status, input ready);
  modport sink (input valid, obstacle_x, obstacle_y, obstacle_status, output ready);
endinterface

### rtl/ustl_front.sv
module ustl_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  ustl_pkg::item_t        item_i,
  output logic                   vld_o,
  output ustl_pkg::geom_t        geom_o,
  output logic [ustl_pkg::QW-1:0] q_o
);
  import ustl_pkg::*;

  localparam int Stages = 7;
  localparam int CmpW   = ((Sum2W > B2W) ? Sum2W : B2W) + 1;
  localparam int HhW    = F1HiW + F2HiW;
  localparam int HlW    = F1HiW + F2LoW;
  localparam int LhW    = F1LoW + F2HiW;
  localparam int LlW    = F1LoW + F2LoW;

  typedef struct packed {
    coord_t                   ax;
    coord_t                   ay;
    logic                     neg;
    obst_status_e             st;
    logic                     calc;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
  } hdr_t;

  logic [Stages-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], vld_i};
    end
  end

  // Stage 1: classify raw status, deltas, sums, squares of distances
  hdr_t                h1_d, h1_q;
  logic [SumW-1:0]     lsum1_q;
  logic [DistBits-1:0] ldif1_q;
  logic [Dif2W-1:0]    l2_1_q, r2_1_q;
  logic [Dif2W-1:0]    le, re;

  always_comb begin
    h1_d.ax   = item_i.ax;
    h1_d.ay   = item_i.ay;
    h1_d.neg  = item_i.heading[HeadBits-1];
    h1_d.dx   = DeltaW'(item_i.bx) - DeltaW'(item_i.ax);
    h1_d.dy   = DeltaW'(item_i.by) - DeltaW'(item_i.ay);
    h1_d.calc = 1'b0;
    priority if (item_i.ls == RawOk && item_i.rs == RawOk) begin
      h1_d.calc = (item_i.l != '0) && (item_i.r != '0);
      h1_d.st   = h1_d.calc ? StNormal : StOver;
    end else if (item_i.ls == RawBlind || item_i.rs == RawBlind) begin
      h1_d.st = StBlind;
    end else if (item_i.ls == RawNoise || item_i.rs == RawNoise) begin
      h1_d.st = StNoise;
    end else begin
      h1_d.st = StInvalid;
    end
  end

  assign le = Dif2W'(item_i.l);
  assign re = Dif2W'(item_i.r);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q    <= h1_d;
      lsum1_q <= SumW'(item_i.l) + SumW'(item_i.r);
      ldif1_q <= (item_i.l > item_i.r) ? item_i.l - item_i.r : item_i.r - item_i.l;
      l2_1_q  <= le * le;
      r2_1_q  <= re * re;
    end
  end

  // Stage 2: squares of deltas and of sum/difference
  hdr_t                    h2_q;
  logic [B2W-1:0]          dxx2_q, dyy2_q;
  logic [Sum2W-1:0]        sum2_2_q;
  logic [Dif2W-1:0]        dif2_2_q;
  logic signed [Dif2W:0]   ldr2_q;
  logic signed [B2W-1:0]   dxe, dye;
  logic [Sum2W-1:0]        se;
  logic [Dif2W-1:0]        de;

  assign dxe = B2W'(h1_q.dx);
  assign dye = B2W'(h1_q.dy);
  assign se  = Sum2W'(lsum1_q);
  assign de  = Dif2W'(ldif1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h2_q     <= h1_q;
      dxx2_q   <= B2W'(dxe * dxe);
      dyy2_q   <= B2W'(dye * dye);
      sum2_2_q <= se * se;
      dif2_2_q <= de * de;
      ldr2_q   <= $signed({1'b0, l2_1_q}) - $signed({1'b0, r2_1_q});
    end
  end

  // Stage 3: squared base length
  hdr_t                  h3_q;
  logic [B2W-1:0]        b2_3_q;
  logic [Sum2W-1:0]      sum2_3_q;
  logic [Dif2W-1:0]      dif2_3_q;
  logic signed [Dif2W:0] ldr3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h3_q     <= h2_q;
      b2_3_q   <= dxx2_q + dyy2_q;
      sum2_3_q <= sum2_2_q;
      dif2_3_q <= dif2_2_q;
      ldr3_q   <= ldr2_q;
    end
  end

  // Stage 4: triangle test, sqrt factors, cosine numerator
  logic [CmpW-1:0] sum2e, b2e, dif2e;
  logic            tri_ok, norm;
  geom_t           g4_d, g4_q;
  logic [F1W-1:0]  f1_q;
  logic [B2W-1:0]  f2_q;

  assign sum2e  = CmpW'(sum2_3_q);
  assign b2e    = CmpW'(b2_3_q);
  assign dif2e  = CmpW'(dif2_3_q);
  assign tri_ok = (sum2e > b2e) && (dif2e < b2e);
  assign norm   = h3_q.calc && tri_ok;

  always_comb begin
    g4_d.ax  = h3_q.ax;
    g4_d.ay  = h3_q.ay;
    g4_d.neg = h3_q.neg;
    g4_d.dx  = h3_q.dx;
    g4_d.dy  = h3_q.dy;
    g4_d.b2  = b2_3_q;
    g4_d.k   = KW'($signed({1'b0, b2_3_q})) + KW'(ldr3_q);
    g4_d.st  = h3_q.calc ? (tri_ok ? StNormal : StInvalid) : h3_q.st;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g4_q <= g4_d;
      f1_q <= norm ? F1W'(sum2e - b2e) : '0;
      f2_q <= norm ? B2W'(b2e - dif2e) : '0;
    end
  end

  // Stage 5: partial products of the radicand
  geom_t          g5_q;
  logic [HhW-1:0] hh_q;
  logic [HlW-1:0] hl_q;
  logic [LhW-1:0] lh_q;
  logic [LlW-1:0] ll_q;
  logic [HhW-1:0] hh_a, hh_b;
  logic [HlW-1:0] hl_a, hl_b;
  logic [LhW-1:0] lh_a, lh_b;
  logic [LlW-1:0] ll_a, ll_b;

  assign hh_a = HhW'(f1_q[F1W-1:F1LoW]);
  assign hh_b = HhW'(f2_q[B2W-1:F2LoW]);
  assign hl_a = HlW'(f1_q[F1W-1:F1LoW]);
  assign hl_b = HlW'(f2_q[F2LoW-1:0]);
  assign lh_a = LhW'(f1_q[F1LoW-1:0]);
  assign lh_b = LhW'(f2_q[B2W-1:F2LoW]);
  assign ll_a = LlW'(f1_q[F1LoW-1:0]);
  assign ll_b = LlW'(f2_q[F2LoW-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g5_q <= g4_q;
      hh_q <= hh_a * hh_b;
      hl_q <= hl_a * hl_b;
      lh_q <= lh_a * lh_b;
      ll_q <= ll_a * ll_b;
    end
  end

  // Stage 6: outer products do not overlap, cross products add
  geom_t         g6_q;
  logic [QW-1:0] qa_q, qb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g6_q <= g5_q;
      qa_q <= {hh_q, ll_q};
      qb_q <= (QW'(hl_q) << F1LoW) + (QW'(lh_q) << F2LoW);
    end
  end

  // Stage 7: radicand
  geom_t         g7_q;
  logic [QW-1:0] q7_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g7_q <= g6_q;
      q7_q <= qa_q + qb_q;
    end
  end

  assign vld_o  = vld_q[Stages-1];
  assign geom_o = g7_q;
  assign q_o    = q7_q;

endmodule

### rtl/ustl_sqrt.sv
module ustl_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  ustl_pkg::geom_t            geom_i,
  input  logic [ustl_pkg::QW-1:0]    q_i,
  output logic                       vld_o,
  output ustl_pkg::geom_t            geom_o,
  output logic [ustl_pkg::RootW-1:0] root_o
);
  import ustl_pkg::*;

  localparam int SqW = QW + 2;

  logic [RootW-1:0] vld_q;
  logic [SqW-1:0]   rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  geom_t            geom_q [RootW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootW-2:0], vld_i};
    end
  end

  // One root bit per stage, most significant first
  for (genvar g = 0; g < RootW; g++) begin : g_stage
    localparam int Bit = RootW - 1 - g;
    logic [SqW-1:0]   rem_in, trial;
    logic [RootW-1:0] root_in;
    geom_t            geom_in;
    logic             take;

    if (g == 0) begin : g_first
      assign rem_in  = SqW'(q_i);
      assign root_in = '0;
      assign geom_in = geom_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign geom_in = geom_q[g-1];
    end

    // (r + 2^bit)^2 - r^2, where r has no bits at or below bit
    assign trial = (SqW'(root_in) << (Bit + 1)) | (SqW'(1) << (2 * Bit));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= take ? rem_in - trial : rem_in;
        root_q[g] <= root_in | (RootW'(take) << Bit);
        geom_q[g] <= geom_in;
      end
    end
  end

  assign vld_o  = vld_q[RootW-1];
  assign geom_o = geom_q[RootW-1];
  assign root_o = root_q[RootW-1];

endmodule

### rtl/ustl_proj.sv
module ustl_proj (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  ustl_pkg::geom_t            geom_i,
  input  logic [ustl_pkg::RootW-1:0] root_i,
  output logic                       vld_o,
  output ustl_pkg::div_tag_t         tag_o,
  output logic [ustl_pkg::MagW-1:0]  mag_x_o,
  output logic [ustl_pkg::MagW-1:0]  mag_y_o,
  output logic [ustl_pkg::DivW-1:0]  dv_o
);
  import ustl_pkg::*;

  localparam int Stages = 4;
  localparam int PkhW   = DeltaW + KHiW;
  localparam int PklW   = DeltaW + KLoW + 1;
  localparam int PshW   = DeltaW + SHiW + 1;
  localparam int PslW   = DeltaW + SLoW + 1;

  typedef struct packed {
    coord_t         ax;
    coord_t         ay;
    logic           neg;
    obst_status_e   st;
    logic [B2W-1:0] b2;
  } base_t;

  logic [Stages-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], vld_i};
    end
  end

  // Stage 1: split products of the deltas with K and with the root
  base_t                  b1_q;
  logic signed [PkhW-1:0] xkh_q, ykh_q, dx_kh, dy_kh, k_hi;
  logic signed [PklW-1:0] xkl_q, ykl_q, dx_kl, dy_kl, k_lo;
  logic signed [PshW-1:0] xsh_q, ysh_q, dx_sh, dy_sh, s_hi;
  logic signed [PslW-1:0] xsl_q, ysl_q, dx_sl, dy_sl, s_lo;

  assign dx_kh = PkhW'(geom_i.dx);
  assign dy_kh = PkhW'(geom_i.dy);
  assign k_hi  = PkhW'($signed(geom_i.k[KW-1:KLoW]));
  assign dx_kl = PklW'(geom_i.dx);
  assign dy_kl = PklW'(geom_i.dy);
  assign k_lo  = PklW'($signed({1'b0, geom_i.k[KLoW-1:0]}));
  assign dx_sh = PshW'(geom_i.dx);
  assign dy_sh = PshW'(geom_i.dy);
  assign s_hi  = PshW'($signed({1'b0, root_i[RootW-1:SLoW]}));
  assign dx_sl = PslW'(geom_i.dx);
  assign dy_sl = PslW'(geom_i.dy);
  assign s_lo  = PslW'($signed({1'b0, root_i[SLoW-1:0]}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q.ax  <= geom_i.ax;
      b1_q.ay  <= geom_i.ay;
      b1_q.neg <= geom_i.neg;
      b1_q.st  <= geom_i.st;
      b1_q.b2  <= geom_i.b2;
      xkh_q    <= dx_kh * k_hi;
      ykh_q    <= dy_kh * k_hi;
      xkl_q    <= dx_kl * k_lo;
      ykl_q    <= dy_kl * k_lo;
      xsh_q    <= dx_sh * s_hi;
      ysh_q    <= dy_sh * s_hi;
      xsl_q    <= dx_sl * s_lo;
      ysl_q    <= dy_sl * s_lo;
    end
  end

  // Stage 2: recombine halves
  base_t                 b2_q;
  logic signed [NKW-1:0] xk_q, yk_q;
  logic signed [NSW-1:0] xs_q, ys_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b2_q <= b1_q;
      xk_q <= (NKW'(xkh_q) <<< KLoW) + NKW'(xkl_q);
      yk_q <= (NKW'(ykh_q) <<< KLoW) + NKW'(ykl_q);
      xs_q <= (NSW'(xsh_q) <<< SLoW) + NSW'(xsl_q);
      ys_q <= (NSW'(ysh_q) <<< SLoW) + NSW'(ysl_q);
    end
  end

  // Stage 3: rotate by +beta or -beta
  base_t                b3_q;
  logic signed [NW-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b3_q <= b2_q;
      if (b2_q.neg) begin
        nx_q <= NW'(xk_q) + NW'(ys_q);
        ny_q <= NW'(yk_q) - NW'(xs_q);
      end else begin
        nx_q <= NW'(xk_q) - NW'(ys_q);
        ny_q <= NW'(yk_q) + NW'(xs_q);
      end
    end
  end

  // Stage 4: magnitude plus half divisor for round to nearest
  logic signed [MagW:0] nxe, nye, b2e, mx, my;
  div_tag_t             tag4_q;
  logic [MagW-1:0]      mx4_q, my4_q;
  logic [DivW-1:0]      dv4_q;

  assign nxe = (MagW + 1)'(nx_q);
  assign nye = (MagW + 1)'(ny_q);
  assign b2e = (MagW + 1)'($signed({1'b0, b3_q.b2}));
  assign mx  = nx_q[NW-1] ? b2e - nxe : nxe + b2e;
  assign my  = ny_q[NW-1] ? b2e - nye : nye + b2e;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag4_q.ax    <= b3_q.ax;
      tag4_q.ay    <= b3_q.ay;
      tag4_q.st    <= b3_q.st;
      tag4_q.neg_x <= nx_q[NW-1];
      tag4_q.neg_y <= ny_q[NW-1];
      mx4_q        <= MagW'(mx);
      my4_q        <= MagW'(my);
      dv4_q        <= {b3_q.b2, 1'b0};
    end
  end

  assign vld_o   = vld_q[Stages-1];
  assign tag_o   = tag4_q;
  assign mag_x_o = mx4_q;
  assign mag_y_o = my4_q;
  assign dv_o    = dv4_q;

endmodule

### rtl/ustl_div.sv
module ustl_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  ustl_pkg::div_tag_t        tag_i,
  input  logic [ustl_pkg::MagW-1:0] mag_x_i,
  input  logic [ustl_pkg::MagW-1:0] mag_y_i,
  input  logic [ustl_pkg::DivW-1:0] dv_i,
  output logic                      vld_o,
  output ustl_pkg::div_tag_t        tag_o,
  output logic [ustl_pkg::QuoW-1:0] quo_x_o,
  output logic [ustl_pkg::QuoW-1:0] quo_y_o
);
  import ustl_pkg::*;

  logic [QuoW-1:0] vld_q;
  logic [DrW-1:0]  rx_q [QuoW];
  logic [DrW-1:0]  ry_q [QuoW];
  logic [QuoW-1:0] qx_q [QuoW];
  logic [QuoW-1:0] qy_q [QuoW];
  logic [DivW-1:0] dv_q [QuoW];
  div_tag_t        tag_q [QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuoW-2:0], vld_i};
    end
  end

  // Restoring division, one quotient bit per stage for both axes
  for (genvar g = 0; g < QuoW; g++) begin : g_stage
    localparam int Sh = QuoW - 1 - g;
    logic [DrW-1:0]  rx_in, ry_in, dsh;
    logic [QuoW-1:0] qx_in, qy_in;
    logic [DivW-1:0] dv_in;
    div_tag_t        tag_in;
    logic            tx, ty;

    if (g == 0) begin : g_first
      assign rx_in  = DrW'(mag_x_i);
      assign ry_in  = DrW'(mag_y_i);
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign dv_in  = dv_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rx_in  = rx_q[g-1];
      assign ry_in  = ry_q[g-1];
      assign qx_in  = qx_q[g-1];
      assign qy_in  = qy_q[g-1];
      assign dv_in  = dv_q[g-1];
      assign tag_in = tag_q[g-1];
    end

    assign dsh = DrW'(dv_in) << Sh;
    assign tx  = rx_in >= dsh;
    assign ty  = ry_in >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[g]  <= tx ? rx_in - dsh : rx_in;
        ry_q[g]  <= ty ? ry_in - dsh : ry_in;
        qx_q[g]  <= qx_in | (QuoW'(tx) << Sh);
        qy_q[g]  <= qy_in | (QuoW'(ty) << Sh);
        dv_q[g]  <= dv_in;
        tag_q[g] <= tag_in;
      end
    end
  end

  assign vld_o   = vld_q[QuoW-1];
  assign tag_o   = tag_q[QuoW-1];
  assign quo_x_o = qx_q[QuoW-1];
  assign quo_y_o = qy_q[QuoW-1];

endmodule

### rtl/ultrasonic_trilateration_locate.sv
// Throughput: one word per cycle unless the output stalls; every stage is
// registered, and the square root and the rounding divider each resolve one
// result bit per stage.
// Reset: rst_ni clears the valid bits only; the block holds no other state and
// is ready for a word on the first cycle after reset.
module ultrasonic_trilateration_locate (
  input  logic              clk_i,
  input  logic              rst_ni,
  ustl_in_if.sink           loc_in_i,
  ustl_out_if.source        loc_out_o
);
  import ustl_pkg::*;

  // Flow control: the whole pipeline advances together. It may advance when the
  // output register is free (empty or being taken) or when the last divider
  // stage holds no word, so interior bubbles are squeezed out under a stall.
  logic out_vld_q;
  logic out_free;
  logic en;

  logic               div_vld;
  div_tag_t           div_tag;
  logic [QuoW-1:0]    quo_x, quo_y;

  assign out_free       = !out_vld_q || loc_out_o.ready;
  assign en             = out_free || !div_vld;
  assign loc_in_i.ready = en;

  // Pack the incoming word
  item_t item;
  assign item.ax      = loc_in_i.sensor_a_x;
  assign item.ay      = loc_in_i.sensor_a_y;
  assign item.heading = loc_in_i.sensor_a_heading;
  assign item.bx      = loc_in_i.sensor_b_x;
  assign item.by      = loc_in_i.sensor_b_y;
  assign item.l       = loc_in_i.left_distance;
  assign item.ls      = loc_in_i.left_status;
  assign item.r       = loc_in_i.right_distance;
  assign item.rs      = loc_in_i.right_status;

  // Front end: status decode, deltas, b^2, triangle test, K and the radicand
  // Q = ((l+r)^2 - b^2) * (b^2 - (l-r)^2), zero when no position is computed.
  logic          fr_vld;
  geom_t         fr_geom;
  logic [QW-1:0] fr_q;

  ustl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (loc_in_i.valid),
    .item_i (item),
    .vld_o  (fr_vld),
    .geom_o (fr_geom),
    .q_o    (fr_q)
  );

  // Integer square root S = floor(sqrt(Q)), geometry rides along
  logic             sq_vld;
  geom_t            sq_geom;
  logic [RootW-1:0] sq_root;

  ustl_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fr_vld),
    .geom_i (fr_geom),
    .q_i    (fr_q),
    .vld_o  (sq_vld),
    .geom_o (sq_geom),
    .root_o (sq_root)
  );

  // Numerators Dx*K -+ Dy*S and Dy*K +- Dx*S, sign taken from the heading,
  // turned into |n| + b^2 so that the divider rounds to nearest, ties away.
  logic            pj_vld;
  div_tag_t        pj_tag;
  logic [MagW-1:0] pj_mag_x, pj_mag_y;
  logic [DivW-1:0] pj_dv;

  ustl_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (sq_vld),
    .geom_i  (sq_geom),
    .root_i  (sq_root),
    .vld_o   (pj_vld),
    .tag_o   (pj_tag),
    .mag_x_o (pj_mag_x),
    .mag_y_o (pj_mag_y),
    .dv_o    (pj_dv)
  );

  // Divide both magnitudes by 2*b^2
  ustl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (pj_vld),
    .tag_i   (pj_tag),
    .mag_x_i (pj_mag_x),
    .mag_y_i (pj_mag_y),
    .dv_i    (pj_dv),
    .vld_o   (div_vld),
    .tag_o   (div_tag),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  // Final: reapply the sign, offset by sensor A, fall back to A for any
  // status other than normal, then saturate to the output range.
  logic signed [PosW-1:0]    off_x, off_y, pos_x, pos_y, ax_e, ay_e;
  logic signed [OutBits-1:0] x_d, y_d;
  logic signed [OutBits-1:0] x_q, y_q;
  obst_status_e              st_q;

  assign ax_e  = PosW'(div_tag.ax);
  assign ay_e  = PosW'(div_tag.ay);
  assign off_x = div_tag.neg_x ? -$signed(PosW'(quo_x)) : $signed(PosW'(quo_x));
  assign off_y = div_tag.neg_y ? -$signed(PosW'(quo_y)) : $signed(PosW'(quo_y));
  assign pos_x = (div_tag.st == StNormal) ? ax_e + off_x : ax_e;
  assign pos_y = (div_tag.st == StNormal) ? ay_e + off_y : ay_e;
  assign x_d   = sat_out(pos_x);
  assign y_d   = sat_out(pos_y);

  // Output register: hold the word until taken, load the next one when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && div_vld) begin
      x_q  <= x_d;
      y_q  <= y_d;
      st_q <= div_tag.st;
    end
  end

  assign loc_out_o.valid           = out_vld_q;
  assign loc_out_o.obstacle_x      = x_q;
  assign loc_out_o.obstacle_y      = y_q;
  assign loc_out_o.obstacle_status = st_q;

endmodule

### tb/tb_ustl_if.sv
`timescale 1ns / 1ps

// Interfaces come from the RTL; this file only lists the probe types used by tb_top.
package tb_ustl_types_pkg;
  import ustl_pkg::*;

  typedef struct {
    logic signed [OutBits-1:0] x;
    logic signed [OutBits-1:0] y;
    obst_status_e              st;
  } obstacle_fix_t;
endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps

// Locate testbench: drives echo-pair words into the trilateration block and
// checks every obstacle word against an integer predictor of the geometry.
module tb_top;
  import ustl_pkg::*;
  import tb_ustl_types_pkg::*;

  localparam int Latency   = 64;
  localparam int NumRandom = 1950;
  localparam longint CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  longint cycle_cnt = 0;
  int     err_cnt;
  bit     no_idle;

  ustl_in_if  loc_in ();
  ustl_out_if loc_out ();

  ultrasonic_trilateration_locate dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .loc_in_i (loc_in.sink),
    .loc_out_o(loc_out.source)
  );

  // Hold expected obstacle words in arrival order.
  obstacle_fix_t fix_q[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat_coord(input longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // Round n / (2*b2) to nearest, ties away from zero.
  function automatic longint div_round(input logic signed [127:0] n, input longint b2);
    logic [127:0] mag;
    logic [127:0] q;
    mag = n[127] ? -n : n;
    q = (mag + b2) / (2 * b2);
    return n[127] ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint isqrt(input logic [127:0] q);
    logic [127:0] root;
    logic [127:0] c;
    root = '0;
    for (int bit_i = 40; bit_i >= 0; bit_i--) begin
      c = root | (128'd1 << bit_i);
      if (c * c <= q) root = c;
    end
    return longint'(root);
  endfunction

  // Solve the sensor triangle and produce the obstacle word.
  function automatic obstacle_fix_t locate_obstacle(input item_t it);
    obstacle_fix_t res;
    longint ax, ay, dx, dy, l, r, b2, sum2, dif2, k, s, sg, px, py;
    logic signed [127:0] nx, ny;
    ax = longint'(it.ax); ay = longint'(it.ay);
    px = ax; py = ay;
    l = longint'(it.l); r = longint'(it.r);
    if (it.ls == RawOk && it.rs == RawOk) begin
      if (l == 0 || r == 0) begin
        res.st = StOver;
      end else begin
        dx = longint'(it.bx) - ax;
        dy = longint'(it.by) - ay;
        b2 = dx * dx + dy * dy;
        sum2 = (l + r) * (l + r);
        dif2 = (l - r) * (l - r);
        if (sum2 > b2 && dif2 < b2) begin
          k = b2 + l * l - r * r;
          s = isqrt(128'(sum2 - b2) * 128'(b2 - dif2));
          sg = (it.heading < 16'h8000) ? 1 : -1;
          nx = 128'(dx) * 128'(k) - 128'(sg * dy) * 128'(s);
          ny = 128'(dy) * 128'(k) + 128'(sg * dx) * 128'(s);
          px = ax + div_round(nx, b2);
          py = ay + div_round(ny, b2);
          res.st = StNormal;
        end else begin
          res.st = StInvalid;
        end
      end
    end else if (it.ls == RawBlind || it.rs == RawBlind) begin
      res.st = StBlind;
    end else if (it.ls == RawNoise || it.rs == RawNoise) begin
      res.st = StNoise;
    end else begin
      res.st = StInvalid;
    end
    res.x = OutBits'(sat_coord(px));
    res.y = OutBits'(sat_coord(py));
    return res;
  endfunction

  function automatic logic [RawBits-1:0] pick_raw();
    unique case ($urandom_range(0, 9))
      0: return RawNoise;
      1: return RawBlind;
      2: return RawBits'($urandom);
      default: return RawOk;
    endcase
  endfunction

  // Mostly solvable triangles: place the obstacle, then measure both echoes.
  function automatic item_t rand_echo();
    item_t it;
    int    span;
    longint ox, oy, lx, ly, rx, ry;
    span = ($urandom_range(0, 9) == 0) ? 32767 : 3000;
    it.ax = CoordBits'(int'($urandom_range(0, 2 * span)) - span);
    it.ay = CoordBits'(int'($urandom_range(0, 2 * span)) - span);
    it.bx = CoordBits'(int'($urandom_range(0, 2 * span)) - span);
    it.by = CoordBits'(int'($urandom_range(0, 2 * span)) - span);
    it.heading = HeadBits'($urandom);
    it.ls = pick_raw();
    it.rs = pick_raw();
    if ($urandom_range(0, 4) == 0) begin
      it.l = DistBits'($urandom);
      it.r = DistBits'($urandom);
    end else begin
      ox = longint'(it.ax) + longint'($urandom_range(0, 6000)) - 3000;
      oy = longint'(it.ay) + longint'($urandom_range(0, 6000)) - 3000;
      lx = ox - it.ax; ly = oy - it.ay;
      rx = ox - it.bx; ry = oy - it.by;
      it.l = DistBits'(isqrt(128'(lx * lx + ly * ly)) + longint'($urandom_range(0, 2)));
      it.r = DistBits'(isqrt(128'(rx * rx + ry * ry)) + longint'($urandom_range(0, 2)));
    end
    return it;
  endfunction

  // Directed words; status column is checked only where has_exp is set.
  typedef struct {
    item_t        it;
    bit           has_exp;
    obst_status_e st;
  } echo_row_t;

  echo_row_t echo_rows[$];

  function automatic item_t mk(input int ax, ay, hd, bx, by, l, ls, r, rs);
    item_t it;
    it.ax = CoordBits'(ax); it.ay = CoordBits'(ay); it.heading = HeadBits'(hd);
    it.bx = CoordBits'(bx); it.by = CoordBits'(by);
    it.l = DistBits'(l); it.ls = RawBits'(ls); it.r = DistBits'(r); it.rs = RawBits'(rs);
    return it;
  endfunction

  task automatic add_row(input item_t it, input bit has_exp, input obst_status_e st);
    echo_row_t row;
    row.it = it; row.has_exp = has_exp; row.st = st;
    echo_rows.push_back(row);
  endtask

  task automatic build_rows();
    add_row(mk(0, 0, 0, 1000, 0, 0, RawOk, 500, RawOk), 1, StOver);
    add_row(mk(10, 20, 0, 1000, 0, 700, RawOk, 0, RawOk), 1, StOver);
    add_row(mk(0, 0, 0, 1000, 0, 500, RawBlind, 500, RawNoise), 1, StBlind);
    add_row(mk(0, 0, 0, 1000, 0, 500, RawNoise, 500, RawBlind), 1, StBlind);
    add_row(mk(0, 0, 0, 1000, 0, 500, RawNoise, 500, RawOk), 1, StNoise);
    add_row(mk(0, 0, 0, 1000, 0, 500, RawOk, 500, RawNoise), 1, StNoise);
    add_row(mk(0, 0, 0, 1000, 0, 500, 8'hFF, 500, 8'h01), 1, StInvalid);
    add_row(mk(0, 0, 0, 1000, 0, 400, RawOk, 500, RawOk), 1, StInvalid);
    add_row(mk(0, 0, 0, 1000, 0, 3000, RawOk, 500, RawOk), 1, StInvalid);
    add_row(mk(5, 5, 0, 5, 5, 500, RawOk, 500, RawOk), 1, StInvalid);
    add_row(mk(0, 0, 0, 1000, 0, 700, RawOk, 700, RawOk), 0, StNormal);
    add_row(mk(0, 0, 16'h7FFF, 1000, 0, 700, RawOk, 700, RawOk), 0, StNormal);
    add_row(mk(0, 0, 16'h8000, 1000, 0, 700, RawOk, 700, RawOk), 0, StNormal);
    add_row(mk(0, 0, 16'hFFFF, 1000, 0, 700, RawOk, 700, RawOk), 0, StNormal);
    add_row(mk(-32768, -32768, 0, 32767, 32767, 65535, RawOk, 65535, RawOk), 0, StNormal);
    add_row(mk(32767, 32767, 16'hFFFF, -32768, -32768, 65535, RawOk, 65535, RawOk),
            0, StNormal);
    add_row(mk(32767, -32768, 0, 32767, 32767, 65535, RawOk, 1, RawOk), 0, StNormal);
    add_row(mk(-32768, 32767, 0, -32767, 32767, 1, RawOk, 1, RawOk), 0, StNormal);
    add_row(mk(-32768, 32767, 0, 32767, -32768, 65535, RawOk, 65535, RawOk), 0, StNormal);
    add_row(mk(100, -100, 0, -900, 200, 1, RawOk, 65535, RawOk), 0, StNormal);
  endtask

  // Drive one word at the falling edge and hold it until accepted.
  task automatic send_echo(input item_t it);
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      loc_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    loc_in.valid            <= 1'b1;
    loc_in.sensor_a_x       <= it.ax;
    loc_in.sensor_a_y       <= it.ay;
    loc_in.sensor_a_heading <= it.heading;
    loc_in.sensor_b_x       <= it.bx;
    loc_in.sensor_b_y       <= it.by;
    loc_in.left_distance    <= it.l;
    loc_in.left_status      <= it.ls;
    loc_in.right_distance   <= it.r;
    loc_in.right_status     <= it.rs;
    @(posedge clk_i);
    while (!loc_in.ready) @(posedge clk_i);
    fix_q.push_back(locate_obstacle(it));
    @(negedge clk_i);
  endtask

  // Stall the result side at random, except during the quiet stretch.
  always @(negedge clk_i) begin
    loc_out.ready <= no_idle || ($urandom_range(0, 99) >= 32);
  end

  // Check each accepted obstacle word against the oldest expectation.
  always @(posedge clk_i) begin
    obstacle_fix_t want;
    if (rst_ni && loc_out.valid && loc_out.ready) begin
      if (fix_q.size() == 0) begin
        $error("obstacle word with nothing expected");
        err_cnt++;
      end else begin
        want = fix_q.pop_front();
        if (loc_out.obstacle_x !== want.x) begin
          $error("obstacle_x expected %0d actual %0d", want.x, loc_out.obstacle_x);
          err_cnt++;
        end
        if (loc_out.obstacle_y !== want.y) begin
          $error("obstacle_y expected %0d actual %0d", want.y, loc_out.obstacle_y);
          err_cnt++;
        end
        if (loc_out.obstacle_status !== want.st) begin
          $error("obstacle_status expected %0d actual %0d", want.st,
                 loc_out.obstacle_status);
          err_cnt++;
        end
      end
    end
  end

  // Abort on a hang.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int settle;
    err_cnt   = 0;
    no_idle   = 1'b0;
    rst_ni    = 1'b0;
    loc_in.valid = 1'b0;
    loc_in.sensor_a_x = '0;
    loc_in.sensor_a_y = '0;
    loc_in.sensor_a_heading = '0;
    loc_in.sensor_b_x = '0;
    loc_in.sensor_b_y = '0;
    loc_in.left_distance = '0;
    loc_in.left_status = '0;
    loc_in.right_distance = '0;
    loc_in.right_status = '0;
    build_rows();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: rows with a typed status must also agree with the predictor.
    foreach (echo_rows[i]) begin
      if (echo_rows[i].has_exp && locate_obstacle(echo_rows[i].it).st != echo_rows[i].st) begin
        $error("obstacle_status expected %0d actual %0d", echo_rows[i].st,
               locate_obstacle(echo_rows[i].it).st);
        err_cnt++;
      end
      send_echo(echo_rows[i].it);
    end

    for (int n = 0; n < NumRandom; n++) begin
      no_idle = (n >= 800 && n < 1100);
      send_echo(rand_echo());
    end
    no_idle = 1'b0;
    loc_in.valid <= 1'b0;

    while (fix_q.size() != 0) @(posedge clk_i);
    settle = 0;
    while (settle < Latency + 10) begin
      @(posedge clk_i);
      settle++;
    end
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ustl_pkg.sv
rtl/ustl_in_if.sv
rtl/ustl_out_if.sv
rtl/ustl_front.sv
rtl/ustl_sqrt.sv
rtl/ustl_proj.sv
rtl/ustl_div.sv
rtl/ultrasonic_trilateration_locate.sv
tb/tb_ustl_if.sv
tb/tb_top.sv
